### hdl/sha1_pkg.sv
// Package for the SHA-1 message hasher.
// Holds initial hash words, round constants and the round function.
// No dependencies.
package sha1_pkg;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic start;
    logic done;
  } core_ctl_t;

  function automatic logic [31:0] round_fk(input logic [6:0] t, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    begin
      if (t < 7'd20) f = ((b & c) | (~b & d)) + K0;
      else if (t < 7'd40) f = (b ^ c ^ d) + K1;
      else if (t < 7'd60) f = ((b & c) | (b & d) | (c & d)) + K2;
      else f = (b ^ c ^ d) + K3;
      return f;
    end
  endfunction

endpackage

### hdl/sha1_message_hasher_top.sv
// Top level of the SHA-1 message hasher: byte intake, padding and digest output.
// Holds the 64-byte block memory and controller; instantiates sha1_core.
// Depends on sha1_pkg and sha1_core.
//
// Usage: message bytes enter one word per cycle on the in_ channel while in_tready
// is high. tdata carries data_byte, tuser carries has_byte, tlast marks the end of
// the message. A closing word may carry no byte. The digest leaves as one word on
// the out_ channel. After every 64th byte the input is held while the 80-round core
// runs one round per cycle out of the block memory and adds the result to the
// chaining value.
// After the last word the padding and the length are written one byte per cycle up
// to the end of the block, then the block is compressed; when fewer than nine bytes
// of room remain, a second block follows.
// Reset returns the chaining value to the initial hash and empties the block.
// The digest sits in an output register; while the receiver stalls, new message
// bytes are still taken, and only the next digest waits for that register.
module sha1_message_hasher_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte[7:0]
  input  logic         in_tuser,   // has_byte
  input  logic         in_tlast,   // last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata   // digest_word0..digest_word4, 32 bits each
);

  localparam logic [2:0] S_FILL = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_HASH = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state_r;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic        fin_r;
  logic [31:0] buf_mem [16];
  logic [3:0]  rd_addr;
  logic [3:0]  core_addr;
  logic [31:0] rd_word_r;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic [7:0]  len_byte;
  sha1_pkg::core_ctl_t ctl_to, ctl_from;
  logic [159:0] chain;
  logic        acc;

  // Memory of 16 big-endian words, written one byte lane at a time.
  always_ff @(posedge clk) begin
    if (wr_en) buf_mem[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    rd_word_r <= buf_mem[rd_addr];
  end

  assign in_tready = (state_r == S_FILL);
  assign acc = in_tvalid && in_tready;
  assign len_byte = 8'(bits_r >> {3'd7 - fill_r[2:0], 3'b000});

  always_comb begin
    wr_en = 1'b0;
    wr_addr = fill_r;
    wr_data = in_tdata;
    if (acc && in_tuser) wr_en = 1'b1;
    else if (state_r == S_PAD) begin
      wr_en = 1'b1;
      wr_data = pad_done_r ? 8'h00 : sha1_pkg::PAD_BYTE;
    end else if (state_r == S_LEN) begin
      wr_en = 1'b1;
      wr_data = len_byte;
    end
  end

  logic       out_valid_r;
  logic       pad_done_r;
  logic       len_done_r;
  logic       out_load;
  logic [159:0] dig_r;

  logic core_busy;
  assign core_busy = ctl_from.start;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign ctl_to = '{start: (state_r == S_HASH), done: out_load};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      fill_r <= '0;
      bits_r <= '0;
      fin_r <= 1'b0;
      pad_done_r <= 1'b0;
      len_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_FILL: begin
          if (acc) begin
            if (in_tuser) begin
              fill_r <= fill_r + 6'd1;
              bits_r <= bits_r + 64'd8;
            end
            fin_r <= in_tlast;
            pad_done_r <= 1'b0;
            len_done_r <= 1'b0;
            if (in_tuser && fill_r == 6'd63) begin
              state_r <= S_HASH;
            end else if (in_tlast) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // The first cycle writes 0x80, later cycles write zeros up to the length.
          if (!pad_done_r) begin
            pad_done_r <= 1'b1;
          end
          fin_r <= 1'b1;
          fill_r <= fill_r + 6'd1;
          if (!pad_done_r && fill_r == 6'd63) state_r <= S_HASH;
          else if (pad_done_r && fill_r == 6'd55) state_r <= S_LEN;
          else if (pad_done_r && fill_r == 6'd63) state_r <= S_HASH;
          else if (!pad_done_r && fill_r == 6'd55) state_r <= S_LEN;
        end
        S_LEN: begin
          fill_r <= fill_r + 6'd1;
          if (fill_r == 6'd63) begin
            state_r <= S_HASH;
            len_done_r <= 1'b1;
          end
        end
        S_HASH: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (ctl_from.done) begin
            fill_r <= '0;
            if (!fin_r) state_r <= S_FILL;
            else if (len_done_r) state_r <= S_OUT;
            else state_r <= S_PAD;
          end
        end
        S_OUT: begin
          bits_r <= '0;
          if (out_load) begin
            dig_r <= chain;
            fin_r <= 1'b0;
            state_r <= S_FILL;
          end
        end
        default: state_r <= S_FILL;
      endcase
    end
  end

  // Round t fetches word t+1 of the block; word 0 is fetched on the start cycle.
  assign rd_addr = (state_r == S_HASH) ? 4'd0 : core_addr;

  sha1_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (ctl_to),
    .ctl_out  (ctl_from),
    .blk_addr (core_addr),
    .blk_word (rd_word_r),
    .chain    (chain)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = dig_r;

  ap_out_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("digest changed while stalled");
  ap_fill_reset_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |=> (fill_r == 6'd0 && bits_r == 64'd0))
    else $error("state not cleared after digest");
  ap_hash_starts_core: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HASH) |=> core_busy) else $error("core did not start");

endmodule

### hdl/sha1_core.sv
// SHA-1 compression core: 80 rounds, one per cycle, words read from a block memory.
// The schedule window is a 16-word memory read and written each round.
// Depends on sha1_pkg.
module sha1_core (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1_pkg::core_ctl_t ctl_in,
  output sha1_pkg::core_ctl_t ctl_out,
  output logic [3:0]          blk_addr,
  input  logic [31:0]         blk_word,
  output logic [159:0]        chain
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;

  logic [1:0]  state_r;
  logic [6:0]  t_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] h_r [5];
  logic [31:0] win_mem [16];
  logic [31:0] w3_r, w8_r, w14_r, w16_r;
  logic [31:0] w_cur;
  logic [31:0] wx;
  logic [6:0]  t_nxt;

  // The newest tap is a shift register of recent words; memory keeps the 16-word history.
  assign wx    = w3_r ^ w8_r ^ w14_r ^ w16_r;
  assign w_cur = (t_r < 7'd16) ? blk_word : {wx[30:0], wx[31]};
  assign t_nxt = t_r + 7'd1;
  assign blk_addr = t_nxt[3:0];

  logic [31:0] rd8_r, rd14_r, rd16_r;

  always_ff @(posedge clk) begin
    if (state_r == S_RUN) begin
      win_mem[t_r[3:0]] <= w_cur;
    end
    rd8_r  <= win_mem[4'(t_nxt[3:0] - 4'd8)];
    rd14_r <= win_mem[4'(t_nxt[3:0] - 4'd14)];
    rd16_r <= win_mem[t_nxt[3:0]];
  end

  // Forwarding: each word written this cycle also enters a shift register for the newest tap.
  logic [31:0] w1_r, w2_r;
  always_ff @(posedge clk) begin
    if (state_r == S_RUN) begin
      w1_r <= w_cur;
      w2_r <= w1_r;
      w3_r <= w2_r;
    end
  end
  assign w8_r  = rd8_r;
  assign w14_r = rd14_r;
  assign w16_r = rd16_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      t_r     <= '0;
      h_r[0] <= sha1_pkg::H0_INIT;
      h_r[1] <= sha1_pkg::H1_INIT;
      h_r[2] <= sha1_pkg::H2_INIT;
      h_r[3] <= sha1_pkg::H3_INIT;
      h_r[4] <= sha1_pkg::H4_INIT;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (ctl_in.done) begin
            h_r[0] <= sha1_pkg::H0_INIT;
            h_r[1] <= sha1_pkg::H1_INIT;
            h_r[2] <= sha1_pkg::H2_INIT;
            h_r[3] <= sha1_pkg::H3_INIT;
            h_r[4] <= sha1_pkg::H4_INIT;
          end else if (ctl_in.start) begin
            state_r <= S_RUN;
            t_r <= '0;
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
          end
        end
        S_RUN: begin
          a_r <= {a_r[26:0], a_r[31:27]} + sha1_pkg::round_fk(t_r, b_r, c_r, d_r)
                 + e_r + w_cur;
          b_r <= a_r;
          c_r <= {b_r[1:0], b_r[31:2]};
          d_r <= c_r;
          e_r <= d_r;
          t_r <= t_nxt;
          if (t_r == 7'd79) state_r <= S_ADD;
        end
        S_ADD: begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign ctl_out = '{start: (state_r != S_IDLE), done: (state_r == S_ADD)};
  assign chain = {h_r[4], h_r[3], h_r[2], h_r[1], h_r[0]};

endmodule

### tb/sv/tb.sv
// Testbench for sha1_message_hasher_top: drives byte streams and checks SHA-1 digests.
// Expected digests come from a behavioral SHA-1 predictor kept in this file.
// Depends on sha1_pkg and sha1_message_hasher_top.
`timescale 1ns / 100ps

module tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [159:0] out_tdata;

  logic [7:0]   msg_buf [0:63];
  int unsigned  msg_fill;
  logic [63:0]  msg_bits;
  logic [31:0]  hash_state [0:4];
  logic [159:0] digest_queue [$];
  int           mismatches;
  int           send_idle_pct;
  int           recv_idle_pct;

  sha1_message_hasher_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress_buffer();
    logic [31:0] w [0:79];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_buf[4*t], msg_buf[4*t+1], msg_buf[4*t+2], msg_buf[4*t+3]};
    for (int t = 16; t < 80; t++)
      w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
    d = hash_state[3]; e = hash_state[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d); k = sha1_pkg::K0;
      end else if (t < 40) begin
        f = b ^ c ^ d; k = sha1_pkg::K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d; k = sha1_pkg::K3;
      end
      tmp = rotl(a, 5) + f + e + k + w[t];
      e = d; d = c; c = rotl(b, 30); b = a; a = tmp;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
    hash_state[3] += d; hash_state[4] += e;
  endtask

  task automatic restart_hash();
    hash_state[0] = sha1_pkg::H0_INIT; hash_state[1] = sha1_pkg::H1_INIT;
    hash_state[2] = sha1_pkg::H2_INIT; hash_state[3] = sha1_pkg::H3_INIT;
    hash_state[4] = sha1_pkg::H4_INIT;
    msg_fill = 0;
    msg_bits = '0;
  endtask

  task automatic predict_word(input logic [7:0] data, input logic has_byte,
                              input logic last);
    int unsigned i;
    if (has_byte) begin
      msg_buf[msg_fill] = data;
      msg_fill++;
      msg_bits += 64'd8;
      if (msg_fill == 64) begin
        compress_buffer();
        msg_fill = 0;
      end
    end
    if (last) begin
      i = msg_fill;
      msg_buf[i] = sha1_pkg::PAD_BYTE;
      i++;
      if (i > 56) begin
        while (i < 64) begin
          msg_buf[i] = 8'h00; i++;
        end
        compress_buffer();
        i = 0;
      end
      while (i < 56) begin
        msg_buf[i] = 8'h00; i++;
      end
      for (int k = 0; k < 8; k++) msg_buf[56+k] = msg_bits[63-8*k -: 8];
      compress_buffer();
      digest_queue.push_back({hash_state[4], hash_state[3], hash_state[2],
                              hash_state[1], hash_state[0]});
      restart_hash();
    end
  endtask

  task automatic send_word(input logic [7:0] data, input logic has_byte,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= has_byte;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(data, has_byte, last);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        if (digest_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected digest %h", out_tdata);
        end else begin
          if (out_tdata !== digest_queue[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Digest mismatch: expected %h actual %h", digest_queue[0], out_tdata);
          end
          void'(digest_queue.pop_front());
        end
      end
    end
  end

  task automatic send_message(input int len, input bit closing_byte);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(15) == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b0);
      send_word(8'($urandom_range(255)), 1'b1, closing_byte && (n == len - 1));
    end
    if (!closing_byte || len == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'hFF, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1);
  endtask

  task automatic test_padding_edges();
    int sizes [8] = '{55, 56, 57, 63, 64, 65, 119, 128};
    foreach (sizes[s]) send_message(sizes[s], s[0]);
  endtask

  task automatic test_drain_pause();
    send_message(10, 1'b1);
    in_tvalid <= 1'b0;
    wait (digest_queue.size() == 0);
    repeat (400) @(posedge clk);
    send_message(3, 1'b0);
  endtask

  task automatic test_random(input int words);
    int sent;
    int len;
    sent = 0;
    while (sent < words) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(70);
      send_message(len, 1'($urandom_range(1)));
      sent += len + 1;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    mismatches = 0;
    send_idle_pct = 15;
    recv_idle_pct = 51;
    restart_hash();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_padding_edges();
    test_drain_pause();
    test_random(440);
    send_idle_pct = 51;
    recv_idle_pct = 15;
    test_random(440);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(440);
    in_tvalid <= 1'b0;
    wait (digest_queue.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
